@@ rtl/asmcls_pkg.sv @@
package asmcls_pkg;

   localparam int MAX_LINE_LENGTH = 255;
   localparam int LINE_COUNT_BITS = 24;

   localparam int COL_W     = $clog2(MAX_LINE_LENGTH + 1);
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int LINE_NO_W = 24;
   localparam int FIELD_W   = 8;

   localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_LINE_LENGTH);
   localparam logic [LINE_COUNT_BITS-1:0] LINE_CNT_MAX = '1;

   localparam logic [BYTE_W-1:0] CHAR_NEWLINE  = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_TAB      = 8'd9;
   localparam logic [BYTE_W-1:0] CHAR_CR       = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_SPACE    = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_PERCENT  = 8'd37;
   localparam logic [BYTE_W-1:0] CHAR_COLON    = 8'd58;
   localparam logic [BYTE_W-1:0] COMMENT_RESET = 8'd59;

   localparam logic [KIND_W-1:0] KIND_INSTRUCTION = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LABEL       = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DIRECTIVE   = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]    line_kind;
      logic [LINE_NO_W-1:0] src_line;
      logic [FIELD_W-1:0]   name_start;
      logic [FIELD_W-1:0]   name_length;
      logic [FIELD_W-1:0]   rest_start;
      logic [FIELD_W-1:0]   rest_length;
      logic                 too_long;
   } rsp_payload_type;

   function automatic logic is_space_char(input logic [BYTE_W-1:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   // Inclusive span length, saturated at the maximum line length.
   function automatic logic [COL_W-1:0] span_len(input logic [COL_W-1:0] s,
                                                 input logic [COL_W-1:0] e);
      logic [COL_W:0] n;
      n = {1'b0, e} - {1'b0, s} + {{COL_W{1'b0}}, 1'b1};
      if (n > {1'b0, COL_MAX}) begin
         return COL_MAX;
      end
      return n[COL_W-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(input logic [COL_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[FIELD_W-1:0];
   endfunction

   function automatic logic [LINE_NO_W-1:0] to_line_no(
      input logic [LINE_COUNT_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[LINE_NO_W-1:0];
   endfunction

endpackage

@@ rtl/asmcls_req_if.sv @@
interface asmcls_req_if;
   logic                            valid;
   logic                            ready;
   logic [asmcls_pkg::BYTE_W-1:0]   text_byte;
   logic                            end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ rtl/asmcls_rsp_if.sv @@
interface asmcls_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [asmcls_pkg::KIND_W-1:0]     line_kind;
   logic [asmcls_pkg::LINE_NO_W-1:0]  src_line;
   logic [asmcls_pkg::FIELD_W-1:0]    name_start;
   logic [asmcls_pkg::FIELD_W-1:0]    name_length;
   logic [asmcls_pkg::FIELD_W-1:0]    rest_start;
   logic [asmcls_pkg::FIELD_W-1:0]    rest_length;
   logic                              too_long;

   modport source (output valid, output line_kind, output src_line, output name_start,
                   output name_length, output rest_start, output rest_length,
                   output too_long, input ready);
   modport sink   (input valid, input line_kind, input src_line, input name_start,
                   input name_length, input rest_start, input rest_length,
                   input too_long, output ready);
endinterface

@@ rtl/assembly_line_classifier_top.sv @@
// A line's result is written to the result register when the byte that ends its line leaves the input register.
// Throughput: one byte per cycle; the per-byte column update and line summary are one
// combinational pass between the input register and the result register. Only a byte
// that ends a line waits, and only while the previous result has not been taken.
// Reset is synchronous and active high: it empties both registers, clears the line
// state and the line counter, and sets the comment character to ';'.
module assembly_line_classifier_top (
   input  logic                          clock,
   input  logic                          reset,
   asmcls_req_if.sink                    req_ch,
   asmcls_rsp_if.source                  rsp_ch,
   input  logic                          csr_we,
   input  logic [asmcls_pkg::BYTE_W-1:0] csr_wdata
);
   import asmcls_pkg::*;

   logic [BYTE_W-1:0] comment_char_ff;

   // Input register.
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;
   logic              s1_advance;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            emit;

   // Line state.
   logic [LINE_COUNT_BITS-1:0] line_cnt_ff, line_cnt_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic in_comment_ff, in_comment_in;
   logic [COL_W-1:0] content_start_ff, content_start_in;
   logic seen_content_ff, seen_content_in;
   logic starts_percent_ff, starts_percent_in;
   logic space_seen_ff, space_seen_in;
   logic colon_seen_ff, colon_seen_in;
   logic [COL_W-1:0] first_colon_col_ff, first_colon_col_in;
   logic [COL_W-1:0] last_ns_col_ff, last_ns_col_in;
   logic last_was_colon_ff, last_was_colon_in;
   logic [COL_W-1:0] last_ns_before_space_ff, last_ns_before_space_in;
   logic [COL_W-1:0] last_ns_before_colon_ff, last_ns_before_colon_in;
   logic after_space_seen_ff, after_space_seen_in;
   logic [COL_W-1:0] first_ns_after_space_ff, first_ns_after_space_in;
   logic dname_seen_ff, dname_seen_in;
   logic [COL_W-1:0] dname_start_ff, dname_start_in;
   logic overflow_ff, overflow_in;

   // A byte that produces no result never waits for the result register.
   assign s1_advance   = s1_valid_ff && (!emit || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign s1_valid_in  = req_ch.valid ? 1'b1 : (s1_valid_ff && !s1_advance);

   always_comb begin
      logic [COL_W-1:0] v_column, col, name_end, ns, nl, rs, rl;
      logic v_in_comment, v_seen, v_percent, v_space, v_colon, v_lwc, v_after;
      logic v_dname, v_ovf, is_nl, end_line;
      logic [COL_W-1:0] v_cstart, v_fcolon, v_lns, v_lnbs, v_lnbc, v_fnas, v_dstart;
      logic [KIND_W-1:0] kind;
      logic [LINE_COUNT_BITS-1:0] cnt_inc;

      v_column     = column_ff;
      v_in_comment = in_comment_ff;
      v_cstart     = content_start_ff;
      v_seen       = seen_content_ff;
      v_percent    = starts_percent_ff;
      v_space      = space_seen_ff;
      v_colon      = colon_seen_ff;
      v_fcolon     = first_colon_col_ff;
      v_lns        = last_ns_col_ff;
      v_lwc        = last_was_colon_ff;
      v_lnbs       = last_ns_before_space_ff;
      v_lnbc       = last_ns_before_colon_ff;
      v_after      = after_space_seen_ff;
      v_fnas       = first_ns_after_space_ff;
      v_dname      = dname_seen_ff;
      v_dstart     = dname_start_ff;
      v_ovf        = overflow_ff;
      col          = column_ff;
      is_nl        = (s1_byte_ff == CHAR_NEWLINE);
      end_line     = is_nl || s1_last_ff;

      if (!is_nl) begin
         // Bytes past the maximum length all land on the last column.
         if (column_ff == COL_MAX) begin
            v_ovf = 1'b1;
         end else begin
            v_column = column_ff + COL_W'(1);
         end
         if (in_comment_ff) begin
         end else if (s1_byte_ff == comment_char_ff) begin
            v_in_comment = 1'b1;
         end else if (is_space_char(s1_byte_ff)) begin
            if ((s1_byte_ff == CHAR_SPACE) && seen_content_ff && !space_seen_ff) begin
               v_space = 1'b1;
            end
         end else begin
            if (!seen_content_ff) begin
               v_seen    = 1'b1;
               v_cstart  = col;
               v_percent = (s1_byte_ff == CHAR_PERCENT);
            end else if (starts_percent_ff && !space_seen_ff && !dname_seen_ff) begin
               v_dname  = 1'b1;
               v_dstart = col;
            end
            if (!space_seen_ff) begin
               v_lnbs = col;
            end else if (!after_space_seen_ff) begin
               v_after = 1'b1;
               v_fnas  = col;
            end
            if (!colon_seen_ff) begin
               if (s1_byte_ff == CHAR_COLON) begin
                  v_colon  = 1'b1;
                  v_fcolon = col;
               end else begin
                  v_lnbc = col;
               end
            end
            v_lns = col;
            v_lwc = (s1_byte_ff == CHAR_COLON);
         end
      end

      name_end = v_space ? v_lnbs : v_lns;
      ns = '0;
      nl = '0;
      rs = '0;
      rl = '0;
      if (v_percent) begin
         kind = KIND_DIRECTIVE;
         if (v_dname) begin
            ns = v_dstart;
            nl = span_len(v_dstart, name_end);
         end
      end else if (v_lwc) begin
         kind = KIND_LABEL;
         // A lone colon is a label with an empty name.
         if (v_fcolon != v_cstart) begin
            ns = v_cstart;
            nl = span_len(v_cstart, v_lnbc);
         end
      end else begin
         kind = KIND_INSTRUCTION;
         ns   = v_cstart;
         nl   = span_len(v_cstart, name_end);
      end
      if ((kind != KIND_LABEL) && v_space && v_after) begin
         rs = v_fnas;
         rl = span_len(v_fnas, v_lns);
      end

      cnt_inc = (line_cnt_ff != LINE_CNT_MAX) ? line_cnt_ff + LINE_COUNT_BITS'(1)
                                              : line_cnt_ff;
      emit = end_line && v_seen;

      rsp_in.line_kind   = kind;
      rsp_in.src_line    = to_line_no(cnt_inc);
      rsp_in.name_start  = to_field(ns);
      rsp_in.name_length = to_field(nl);
      rsp_in.rest_start  = to_field(rs);
      rsp_in.rest_length = to_field(rl);
      rsp_in.too_long    = v_ovf;

      if (end_line) begin
         line_cnt_in             = s1_last_ff ? '0 : cnt_inc;
         column_in               = '0;
         in_comment_in           = 1'b0;
         content_start_in        = '0;
         seen_content_in         = 1'b0;
         starts_percent_in       = 1'b0;
         space_seen_in           = 1'b0;
         colon_seen_in           = 1'b0;
         first_colon_col_in      = '0;
         last_ns_col_in          = '0;
         last_was_colon_in       = 1'b0;
         last_ns_before_space_in = '0;
         last_ns_before_colon_in = '0;
         after_space_seen_in     = 1'b0;
         first_ns_after_space_in = '0;
         dname_seen_in           = 1'b0;
         dname_start_in          = '0;
         overflow_in             = 1'b0;
      end else begin
         line_cnt_in             = line_cnt_ff;
         column_in               = v_column;
         in_comment_in           = v_in_comment;
         content_start_in        = v_cstart;
         seen_content_in         = v_seen;
         starts_percent_in       = v_percent;
         space_seen_in           = v_space;
         colon_seen_in           = v_colon;
         first_colon_col_in      = v_fcolon;
         last_ns_col_in          = v_lns;
         last_was_colon_in       = v_lwc;
         last_ns_before_space_in = v_lnbs;
         last_ns_before_colon_in = v_lnbc;
         after_space_seen_in     = v_after;
         first_ns_after_space_in = v_fnas;
         dname_seen_in           = v_dname;
         dname_start_in          = v_dstart;
         overflow_in             = v_ovf;
      end
   end

   assign rsp_valid_in = (s1_advance && emit) ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_char_ff <= COMMENT_RESET;
      end else if (csr_we) begin
         comment_char_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_byte_ff <= req_ch.text_byte;
         s1_last_ff <= req_ch.end_of_text;
      end
      if (s1_advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cnt_ff             <= '0;
         column_ff               <= '0;
         in_comment_ff           <= 1'b0;
         content_start_ff        <= '0;
         seen_content_ff         <= 1'b0;
         starts_percent_ff       <= 1'b0;
         space_seen_ff           <= 1'b0;
         colon_seen_ff           <= 1'b0;
         first_colon_col_ff      <= '0;
         last_ns_col_ff          <= '0;
         last_was_colon_ff       <= 1'b0;
         last_ns_before_space_ff <= '0;
         last_ns_before_colon_ff <= '0;
         after_space_seen_ff     <= 1'b0;
         first_ns_after_space_ff <= '0;
         dname_seen_ff           <= 1'b0;
         dname_start_ff          <= '0;
         overflow_ff             <= 1'b0;
      end else if (s1_advance) begin
         line_cnt_ff             <= line_cnt_in;
         column_ff               <= column_in;
         in_comment_ff           <= in_comment_in;
         content_start_ff        <= content_start_in;
         seen_content_ff         <= seen_content_in;
         starts_percent_ff       <= starts_percent_in;
         space_seen_ff           <= space_seen_in;
         colon_seen_ff           <= colon_seen_in;
         first_colon_col_ff      <= first_colon_col_in;
         last_ns_col_ff          <= last_ns_col_in;
         last_was_colon_ff       <= last_was_colon_in;
         last_ns_before_space_ff <= last_ns_before_space_in;
         last_ns_before_colon_ff <= last_ns_before_colon_in;
         after_space_seen_ff     <= after_space_seen_in;
         first_ns_after_space_ff <= first_ns_after_space_in;
         dname_seen_ff           <= dname_seen_in;
         dname_start_ff          <= dname_start_in;
         overflow_ff             <= overflow_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.line_kind   = rsp_ff.line_kind;
   assign rsp_ch.src_line    = rsp_ff.src_line;
   assign rsp_ch.name_start  = rsp_ff.name_start;
   assign rsp_ch.name_length = rsp_ff.name_length;
   assign rsp_ch.rest_start  = rsp_ff.rest_start;
   assign rsp_ch.rest_length = rsp_ff.rest_length;
   assign rsp_ch.too_long    = rsp_ff.too_long;

endmodule
